@@ hw/rtl/c2d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package c2d_pkg;

   // geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_KERNEL = 4;
   localparam int LS_ROWS    = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

   // field and register widths
   localparam int PIX_W     = 16;
   localparam int COEF_W    = 16;
   localparam int CFG_W     = 64;
   localparam int DIM_W     = 11;
   localparam int KSZ_W     = 3;
   localparam int POS_W     = 10;
   localparam int SUM_W     = 40;
   localparam int CSR_IDX_W = 3;

   // derived widths
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int WEFF_W   = $clog2(MAX_WIDTH + 1);
   localparam int HEFF_W   = $clog2(MAX_HEIGHT + 1);
   localparam int KEFF_W   = $clog2(MAX_KERNEL + 1);
   localparam int BANK_W   = (LS_ROWS > 1) ? $clog2(LS_ROWS) : 1;
   localparam int PROD_W   = PIX_W + COEF_W;
   localparam int ROWSUM_W = PROD_W + $clog2(MAX_KERNEL);
   localparam int TOTAL_W  = ROWSUM_W + $clog2(MAX_KERNEL);

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_KERNEL_SIZE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_KERNEL_ROW_A = 3'd3;

   // source of a new window column entry
   localparam int SRC_W = 2;
   localparam logic [SRC_W-1:0] SRC_ZERO  = 2'd0;
   localparam logic [SRC_W-1:0] SRC_PIXEL = 2'd1;
   localparam logic [SRC_W-1:0] SRC_LINE  = 2'd2;

   typedef logic signed [PIX_W-1:0]    pix_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ROWSUM_W-1:0] rowsum_type;
   typedef logic signed [TOTAL_W-1:0]  total_type;

   typedef struct packed {
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             frame_end;
   } meta_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [POS_W-1:0]        out_row;
      logic [POS_W-1:0]        out_col;
      logic                    frame_end;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/conv2d_valid_correlation_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A result beat passes the window, product, row-sum and total registers, then the result queue.
// Throughput: one pixel per cycle sustained while req_stall is low; each pixel does one read
// and one lane write of the line memory at its column, both in the accept cycle.
// Up to 8 results may be pending (pipeline plus result queue); req_stall rises at that point.
// Reset (synchronous): position, window, queue and registers return to their defaults.
// The line memory has no reset and no clearing pass.
module conv2d_valid_correlation_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [c2d_pkg::PIX_W-1:0]      req_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [c2d_pkg::SUM_W-1:0]      rsp_sum,
   output logic [c2d_pkg::POS_W-1:0]             rsp_out_row,
   output logic [c2d_pkg::POS_W-1:0]             rsp_out_col,
   output logic                                  rsp_frame_end,
   input  logic                                  csr_wr_en,
   input  logic [c2d_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [c2d_pkg::CFG_W-1:0]             csr_wdata
);

   localparam int MK = c2d_pkg::MAX_KERNEL;

   // ---------------- configuration ----------------
   logic [c2d_pkg::DIM_W-1:0] image_width_ff;
   logic [c2d_pkg::DIM_W-1:0] image_height_ff;
   logic [c2d_pkg::KSZ_W-1:0] kernel_size_ff;
   logic [c2d_pkg::CFG_W-1:0] kernel_row_ff [MK];

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= c2d_pkg::DIM_W'(1024);
         image_height_ff <= c2d_pkg::DIM_W'(1024);
         kernel_size_ff  <= c2d_pkg::KSZ_W'(3);
         for (int i = 0; i < MK; i++) begin
            kernel_row_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         if (csr_index == c2d_pkg::CFG_IMAGE_WIDTH) begin
            image_width_ff <= csr_wdata[c2d_pkg::DIM_W-1:0];
         end
         if (csr_index == c2d_pkg::CFG_IMAGE_HEIGHT) begin
            image_height_ff <= csr_wdata[c2d_pkg::DIM_W-1:0];
         end
         if (csr_index == c2d_pkg::CFG_KERNEL_SIZE) begin
            kernel_size_ff <= csr_wdata[c2d_pkg::KSZ_W-1:0];
         end
         for (int i = 0; i < MK; i++) begin
            if (csr_index == c2d_pkg::CFG_KERNEL_ROW_A + c2d_pkg::CSR_IDX_W'(i)) begin
               kernel_row_ff[i] <= csr_wdata;
            end
         end
      end
   end

   logic [c2d_pkg::WEFF_W-1:0] w_eff;
   logic [c2d_pkg::HEFF_W-1:0] h_eff;
   logic [c2d_pkg::KEFF_W-1:0] k_eff;

   always_comb begin
      w_eff = c2d_pkg::WEFF_W'(image_width_ff);
      if (image_width_ff == '0) begin
         w_eff = c2d_pkg::WEFF_W'(1);
      end else if (int'(image_width_ff) > c2d_pkg::MAX_WIDTH) begin
         w_eff = c2d_pkg::WEFF_W'(c2d_pkg::MAX_WIDTH);
      end
      h_eff = c2d_pkg::HEFF_W'(image_height_ff);
      if (image_height_ff == '0) begin
         h_eff = c2d_pkg::HEFF_W'(1);
      end else if (int'(image_height_ff) > c2d_pkg::MAX_HEIGHT) begin
         h_eff = c2d_pkg::HEFF_W'(c2d_pkg::MAX_HEIGHT);
      end
      k_eff = c2d_pkg::KEFF_W'(kernel_size_ff);
      if (kernel_size_ff == '0) begin
         k_eff = c2d_pkg::KEFF_W'(1);
      end else if (int'(kernel_size_ff) > MK) begin
         k_eff = c2d_pkg::KEFF_W'(MK);
      end
   end

   // coefficients lined up with window columns; zero outside the active KxK corner
   c2d_pkg::coef_type coef_pos_in [MK][MK];
   c2d_pkg::coef_type coef_pos_ff [MK][MK];

   always_comb begin
      int jj;
      jj = 0;
      for (int i = 0; i < MK; i++) begin
         for (int m = 0; m < MK; m++) begin
            coef_pos_in[i][m] = '0;
            jj = m - MK + int'(k_eff);
            if (i < int'(k_eff) && jj >= 0) begin
               coef_pos_in[i][m] = kernel_row_ff[i][jj*c2d_pkg::COEF_W +: c2d_pkg::COEF_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      coef_pos_ff <= coef_pos_in;
   end

   // ---------------- accept stage ----------------
   logic [c2d_pkg::COL_W-1:0]  col_ff, col_in;
   logic [c2d_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [c2d_pkg::BANK_W-1:0] slot_ff, slot_in;   // row_ff mod LS_ROWS
   logic                       req_fire;
   logic                       emit;
   c2d_pkg::meta_type          meta_in;
   logic [c2d_pkg::SRC_W-1:0]  src_in  [MK];
   logic [c2d_pkg::BANK_W-1:0] bank_in [MK];
   logic [c2d_pkg::WEFF_W-1:0] col_ext, col_p1;
   logic [c2d_pkg::HEFF_W-1:0] row_ext, row_p1;

   assign req_fire = req_valid && !req_stall;

   always_comb begin
      col_ext = c2d_pkg::WEFF_W'(col_ff);
      col_p1  = col_ext + c2d_pkg::WEFF_W'(1);
      row_ext = c2d_pkg::HEFF_W'(row_ff);
      row_p1  = row_ext + c2d_pkg::HEFF_W'(1);

      emit = (col_ext < w_eff) && (row_ext < h_eff) &&
             (row_p1 >= c2d_pkg::HEFF_W'(k_eff)) && (col_p1 >= c2d_pkg::WEFF_W'(k_eff));
      meta_in.out_row   = c2d_pkg::POS_W'(row_p1 - c2d_pkg::HEFF_W'(k_eff));
      meta_in.out_col   = c2d_pkg::POS_W'(col_p1 - c2d_pkg::WEFF_W'(k_eff));
      meta_in.frame_end = (row_p1 == h_eff) && (col_p1 == w_eff);

      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (col_p1 >= w_eff) begin
         col_in = '0;
         if (row_p1 >= h_eff) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = c2d_pkg::ROW_W'(row_p1);
            slot_in = (int'(slot_ff) == c2d_pkg::LS_ROWS - 1) ? '0
                                                               : slot_ff + 1'b1;
         end
      end else begin
         col_in = c2d_pkg::COL_W'(col_p1);
         // position left past the frame end by a height change
         if (row_ext >= h_eff) begin
            row_in  = '0;
            slot_in = '0;
         end
      end
   end

   // window row i takes image row r-k+1+i: the new pixel, a stored row, or zero
   always_comb begin
      int back_rows;
      int bsel;
      back_rows = 0;
      bsel = 0;
      for (int i = 0; i < MK; i++) begin
         src_in[i]  = c2d_pkg::SRC_ZERO;
         bank_in[i] = '0;
         if (int'(k_eff) == i + 1) begin
            src_in[i] = c2d_pkg::SRC_PIXEL;
         end else if (int'(k_eff) > i + 1) begin
            back_rows = int'(k_eff) - 1 - i;
            if (int'(row_ff) >= back_rows) begin
               src_in[i] = c2d_pkg::SRC_LINE;
               bsel = int'(slot_ff) + c2d_pkg::LS_ROWS - back_rows;
               if (bsel >= c2d_pkg::LS_ROWS) begin
                  bsel = bsel - c2d_pkg::LS_ROWS;
               end
               bank_in[i] = c2d_pkg::BANK_W'(bsel);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (req_fire) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // line memory: one word per column, one lane per stored row.
   // Read and lane write share the accept cycle, so the read sees the old rows.
   logic [c2d_pkg::LS_ROWS*c2d_pkg::PIX_W-1:0] line_mem [c2d_pkg::MAX_WIDTH];
   logic [c2d_pkg::LS_ROWS*c2d_pkg::PIX_W-1:0] line_rd_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_rd_ff <= line_mem[col_ff];
         for (int b = 0; b < c2d_pkg::LS_ROWS; b++) begin
            if (int'(slot_ff) == b) begin
               line_mem[col_ff][b*c2d_pkg::PIX_W +: c2d_pkg::PIX_W] <= req_pixel;
            end
         end
      end
   end

   // ---------------- window stage ----------------
   logic                       s1_valid_ff;
   logic                       s1_emit_ff;
   c2d_pkg::pix_type           s1_px_ff;
   logic [c2d_pkg::SRC_W-1:0]  s1_src_ff  [MK];
   logic [c2d_pkg::BANK_W-1:0] s1_bank_ff [MK];
   c2d_pkg::meta_type          s1_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
      if (req_fire) begin
         s1_emit_ff <= emit;
         s1_px_ff   <= req_pixel;
         s1_src_ff  <= src_in;
         s1_bank_ff <= bank_in;
         s1_meta_ff <= meta_in;
      end
   end

   c2d_pkg::pix_type line_word [c2d_pkg::LS_ROWS];
   c2d_pkg::pix_type window_ff [MK][MK];
   c2d_pkg::pix_type window_in [MK][MK];

   always_comb begin
      for (int b = 0; b < c2d_pkg::LS_ROWS; b++) begin
         line_word[b] = line_rd_ff[b*c2d_pkg::PIX_W +: c2d_pkg::PIX_W];
      end
      window_in = window_ff;
      if (s1_valid_ff) begin
         for (int i = 0; i < MK; i++) begin
            for (int j = 0; j < MK - 1; j++) begin
               window_in[i][j] = window_ff[i][j+1];
            end
            unique case (s1_src_ff[i])
               c2d_pkg::SRC_PIXEL: window_in[i][MK-1] = s1_px_ff;
               c2d_pkg::SRC_LINE:  window_in[i][MK-1] = line_word[s1_bank_ff[i]];
               default:            window_in[i][MK-1] = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MK; i++) begin
            for (int j = 0; j < MK; j++) begin
               window_ff[i][j] <= '0;
            end
         end
      end else begin
         window_ff <= window_in;
      end
   end

   // ---------------- product, row sum, total ----------------
   logic               s2_valid_ff, s3_valid_ff, s4_valid_ff;
   c2d_pkg::meta_type  s2_meta_ff, s3_meta_ff, s4_meta_ff;
   c2d_pkg::prod_type  s2_prod_ff [MK][MK];
   c2d_pkg::rowsum_type s3_rsum_ff [MK];
   c2d_pkg::rowsum_type rsum_in    [MK];
   c2d_pkg::total_type s4_sum_ff;
   c2d_pkg::total_type total_in;

   always_comb begin
      for (int i = 0; i < MK; i++) begin
         rsum_in[i] = '0;
         for (int m = 0; m < MK; m++) begin
            rsum_in[i] = rsum_in[i] + c2d_pkg::ROWSUM_W'(s2_prod_ff[i][m]);
         end
      end
      total_in = '0;
      for (int i = 0; i < MK; i++) begin
         total_in = total_in + c2d_pkg::TOTAL_W'(s3_rsum_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      if (s1_valid_ff && s1_emit_ff) begin
         s2_meta_ff <= s1_meta_ff;
         for (int i = 0; i < MK; i++) begin
            for (int m = 0; m < MK; m++) begin
               s2_prod_ff[i][m] <= window_in[i][m] * coef_pos_ff[i][m];
            end
         end
      end
      if (s2_valid_ff) begin
         s3_meta_ff <= s2_meta_ff;
         s3_rsum_ff <= rsum_in;
      end
      if (s3_valid_ff) begin
         s4_meta_ff <= s3_meta_ff;
         s4_sum_ff  <= total_in;
      end
   end

   // ---------------- result queue ----------------
   c2d_pkg::result_type         fifo_ff [c2d_pkg::FIFO_DEPTH];
   logic [c2d_pkg::FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [c2d_pkg::OCC_W-1:0]   fifo_cnt_ff, fifo_cnt_in;
   logic [c2d_pkg::OCC_W-1:0]   occ_ff, occ_in;    // results owed: in flight plus queued
   logic                        push, pop;
   c2d_pkg::result_type         push_data;

   assign push = s4_valid_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      push_data.sum       = c2d_pkg::SUM_W'(s4_sum_ff);
      push_data.out_row   = s4_meta_ff.out_row;
      push_data.out_col   = s4_meta_ff.out_col;
      push_data.frame_end = s4_meta_ff.frame_end;
      fifo_cnt_in = fifo_cnt_ff + c2d_pkg::OCC_W'(push) - c2d_pkg::OCC_W'(pop);
      occ_in      = occ_ff + c2d_pkg::OCC_W'(req_fire && emit) - c2d_pkg::OCC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         occ_ff      <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fifo_cnt_ff <= fifo_cnt_in;
         occ_ff      <= occ_in;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign req_stall     = occ_ff >= c2d_pkg::OCC_W'(c2d_pkg::FIFO_DEPTH);
   assign rsp_valid     = fifo_cnt_ff != '0;
   assign rsp_sum       = fifo_ff[rd_ptr_ff].sum;
   assign rsp_out_row   = fifo_ff[rd_ptr_ff].out_row;
   assign rsp_out_col   = fifo_ff[rd_ptr_ff].out_col;
   assign rsp_frame_end = fifo_ff[rd_ptr_ff].frame_end;

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= c2d_pkg::OCC_W'(c2d_pkg::FIFO_DEPTH))
      else $error("pending result count above queue depth");

   a_queue_within_owed: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= occ_ff)
      else $error("queue holds more results than are owed");

   a_emit_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit) |-> ##4 s4_valid_ff)
      else $error("result-producing beat did not reach the queue in time");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_cnt_ff != c2d_pkg::OCC_W'(c2d_pkg::FIFO_DEPTH)))
      else $error("push into a full result queue");
`endif

endmodule

`default_nettype wire
